// ----- hw/rtl/psd_pkg.sv -----
package psd_pkg;

   localparam int DIM_BITS_DEFAULT = 16;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_6     = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

   typedef enum logic [3:0] {
      PH_MAGIC0,
      PH_MAGIC1_OK,
      PH_MAGIC1_BAD,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAXVAL,
      PH_PIX_TEXT,
      PH_PIX_BIN,
      PH_DONE,
      PH_ERROR
   } psd_phase_type;

   typedef struct packed {
      logic in_comment;
      logic in_token;
      logic digits_stopped;
   } psd_scan_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        ascii_mode;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] column;
      logic [15:0] row;
      logic        last_pixel;
   } psd_result_type;

endpackage

// ----- hw/rtl/psd_scanner.sv -----
module psd_scanner
   import psd_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic [7:0]          byte_in,
   input  logic                saturate,
   input  psd_scan_type        scan_cur,
   input  logic [DIM_BITS-1:0] token_cur,
   output psd_scan_type        scan_next,
   output logic [DIM_BITS-1:0] token_next,
   output logic                token_end
);

   localparam int VW = DIM_BITS + 4;

   logic          is_ws;
   logic          is_digit;
   logic          process;
   logic [VW-1:0] acc;

   always_comb begin
      is_ws    = (byte_in == CHAR_SPACE) || (byte_in inside {[CHAR_TAB:CHAR_CR]});
      is_digit = byte_in inside {[CHAR_ZERO:CHAR_NINE]};
      acc      = VW'(token_cur) * VW'(10) + VW'(byte_in[3:0]);
   end

   always_comb begin
      scan_next  = scan_cur;
      token_next = token_cur;
      token_end  = 1'b0;
      process    = 1'b0;
      if (scan_cur.in_comment) begin
         if (byte_in == CHAR_LF) begin
            scan_next.in_comment = 1'b0;
         end
      end else if (!scan_cur.in_token) begin
         if (byte_in == CHAR_HASH) begin
            scan_next.in_comment = 1'b1;
         end else if (!is_ws) begin
            scan_next.in_token       = 1'b1;
            scan_next.digits_stopped = 1'b0;
            token_next               = '0;
            process                  = 1'b1;
         end
      end else begin
         process = 1'b1;
      end

      if (process) begin
         if (is_ws) begin
            scan_next.in_token = 1'b0;
            token_end          = 1'b1;
         end else if (!scan_next.digits_stopped && is_digit) begin
            if (!scan_cur.in_token) begin
               token_next = DIM_BITS'(byte_in[3:0]);
            end else if (saturate && (acc > VW'({DIM_BITS{1'b1}}))) begin
               token_next = {DIM_BITS{1'b1}};
            end else begin
               token_next = acc[DIM_BITS-1:0];
            end
         end else begin
            scan_next.digits_stopped = 1'b1;
         end
      end
   end

endmodule

// ----- hw/rtl/psd_core.sv -----
module psd_core
   import psd_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [7:0]     in_byte,
   input  logic           in_sof,
   input  logic           rsp_ready,
   output logic           in_take,
   output logic           rsp_valid,
   output psd_result_type rsp_data
);

   psd_phase_type       phase_ff, phase_in, phase_cur;
   logic                text_ff, text_in, text_cur;
   psd_scan_type        scan_ff, scan_in, scan_cur, scan_step;
   logic [DIM_BITS-1:0] token_ff, token_in, token_cur, token_step;
   logic [DIM_BITS-1:0] width_ff, width_in, width_cur;
   logic [DIM_BITS-1:0] height_ff, height_in, height_cur;
   logic [1:0]          comp_ff, comp_in, comp_cur;
   logic [7:0]          red_ff, red_in, red_cur;
   logic [7:0]          green_ff, green_in, green_cur;
   logic [DIM_BITS-1:0] col_ff, col_in, col_cur;
   logic [DIM_BITS-1:0] row_ff, row_in, row_cur;
   logic                rsp_valid_ff, rsp_valid_in;
   psd_result_type      rsp_data_ff;

   logic                token_end;
   logic                take_comp;
   logic [7:0]          comp_val;
   logic [DIM_BITS:0]   col_inc, row_inc, row_after;
   logic                last;
   logic                res_valid;
   psd_result_type      res;

   assign in_take   = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (in_sof) begin
         phase_cur  = PH_MAGIC0;
         text_cur   = 1'b0;
         scan_cur   = '0;
         token_cur  = '0;
         width_cur  = '0;
         height_cur = '0;
         comp_cur   = '0;
         red_cur    = '0;
         green_cur  = '0;
         col_cur    = '0;
         row_cur    = '0;
      end else begin
         phase_cur  = phase_ff;
         text_cur   = text_ff;
         scan_cur   = scan_ff;
         token_cur  = token_ff;
         width_cur  = width_ff;
         height_cur = height_ff;
         comp_cur   = comp_ff;
         red_cur    = red_ff;
         green_cur  = green_ff;
         col_cur    = col_ff;
         row_cur    = row_ff;
      end
   end

   psd_scanner #(
      .DIM_BITS(DIM_BITS)
   ) u_scanner (
      .byte_in   (in_byte),
      .saturate  (phase_cur != PH_PIX_TEXT),
      .scan_cur  (scan_cur),
      .token_cur (token_cur),
      .scan_next (scan_step),
      .token_next(token_step),
      .token_end (token_end)
   );

   always_comb begin
      col_inc   = {1'b0, col_cur} + {{DIM_BITS{1'b0}}, 1'b1};
      row_inc   = {1'b0, row_cur} + {{DIM_BITS{1'b0}}, 1'b1};
      last      = (row_inc == {1'b0, height_cur}) && (col_inc == {1'b0, width_cur});
      row_after = (col_inc >= {1'b0, width_cur}) ? row_inc : {1'b0, row_cur};
   end

   always_comb begin
      phase_in  = phase_cur;
      text_in   = text_cur;
      scan_in   = scan_cur;
      token_in  = token_cur;
      width_in  = width_cur;
      height_in = height_cur;
      comp_in   = comp_cur;
      red_in    = red_cur;
      green_in  = green_cur;
      col_in    = col_cur;
      row_in    = row_cur;
      take_comp = 1'b0;
      comp_val  = in_byte;
      res_valid = 1'b0;
      res       = '0;

      case (phase_cur)
         PH_MAGIC0: begin
            phase_in = (in_byte == CHAR_P) ? PH_MAGIC1_OK : PH_MAGIC1_BAD;
         end
         PH_MAGIC1_OK: begin
            if (in_byte == CHAR_3 || in_byte == CHAR_6) begin
               text_in  = (in_byte == CHAR_3);
               scan_in  = '0;
               token_in = '0;
               phase_in = PH_WIDTH;
            end else begin
               phase_in  = PH_ERROR;
               res_valid = 1'b1;
               res.kind  = KIND_BAD_MAGIC;
            end
         end
         PH_MAGIC1_BAD: begin
            phase_in  = PH_ERROR;
            res_valid = 1'b1;
            res.kind  = KIND_BAD_MAGIC;
         end
         PH_WIDTH: begin
            scan_in  = scan_step;
            token_in = token_step;
            if (token_end) begin
               width_in = token_step;
               phase_in = PH_HEIGHT;
            end
         end
         PH_HEIGHT: begin
            scan_in  = scan_step;
            token_in = token_step;
            if (token_end) begin
               height_in = token_step;
               phase_in  = PH_MAXVAL;
            end
         end
         PH_MAXVAL: begin
            scan_in  = scan_step;
            token_in = token_step;
            if (token_end) begin
               comp_in = '0;
               col_in  = '0;
               row_in  = '0;
               if (width_cur == '0 || height_cur == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = text_cur ? PH_PIX_TEXT : PH_PIX_BIN;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_HEADER;
               res.image_width  = 16'(width_cur);
               res.image_height = 16'(height_cur);
               res.ascii_mode   = text_cur;
            end
         end
         PH_PIX_TEXT: begin
            scan_in   = scan_step;
            token_in  = token_step;
            take_comp = token_end;
            comp_val  = token_step[7:0];
         end
         PH_PIX_BIN: begin
            take_comp = 1'b1;
         end
         default: begin
         end
      endcase

      if (take_comp) begin
         case (comp_cur)
            2'd0: begin
               red_in  = comp_val;
               comp_in = 2'd1;
            end
            2'd1: begin
               green_in = comp_val;
               comp_in  = 2'd2;
            end
            default: begin
               comp_in          = 2'd0;
               res_valid        = 1'b1;
               res.kind         = KIND_PIXEL;
               res.image_width  = 16'(width_cur);
               res.image_height = 16'(height_cur);
               res.ascii_mode   = text_cur;
               res.red          = red_cur;
               res.green        = green_cur;
               res.blue         = comp_val;
               res.column       = 16'(col_cur);
               res.row          = 16'(row_cur);
               res.last_pixel   = last;
               col_in = (col_inc >= {1'b0, width_cur}) ? '0 : col_inc[DIM_BITS-1:0];
               row_in = row_after[DIM_BITS-1:0];
               if (last || row_after >= {1'b0, height_cur}) begin
                  phase_in = PH_DONE;
               end
            end
         endcase
      end

      if (in_take) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC0;
         text_ff      <= 1'b0;
         scan_ff      <= '0;
         token_ff     <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         comp_ff      <= '0;
         red_ff       <= '0;
         green_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_take) begin
            phase_ff  <= phase_in;
            text_ff   <= text_in;
            scan_ff   <= scan_in;
            token_ff  <= token_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            comp_ff   <= comp_in;
            red_ff    <= red_in;
            green_ff  <= green_in;
            col_ff    <= col_in;
            row_ff    <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && res_valid) begin
         rsp_data_ff <= res;
      end
   end

endmodule

// ----- hw/rtl/ppm_stream_decoder.sv -----
// PPM image decoder (P3 text and P6 binary), one file byte per request.
// Request channel: req_tdata carries one byte of the file, req_tuser marks
// the first byte of a new file and restarts the parser on that byte.
// Response channel: one response for the parsed header, one per RGB pixel
// in row-major order, or one bad-magic error; rsp_tuser gives the kind and
// the text/binary mode, rsp_tlast marks the final pixel.
// Bytes that complete no response (magic, whitespace, digits, comments,
// first two components of a pixel) produce nothing.
// Throughput: one request per cycle, sustained while rsp_tready stays high;
// the full byte update is one pass of the token scanner and pixel counters
// between the request register and the response register.
// Each accepted request is held in the request register; its response is
// registered in the response register and presented from there.
// When the receiver stalls, the response register holds; one more request
// is buffered in the request register, then req_tready drops.
// Reset clears the parser to expect the first magic byte and empties both
// registers.
module ppm_stream_decoder
   import psd_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tuser,   // [0] start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // image_width, image_height, red, green, blue, column, row
   output logic [2:0]  rsp_tuser,   // [1:0] kind, [2] ascii_mode
   output logic        rsp_tlast    // last_pixel
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_sof_ff;
   logic           in_take;
   logic           req_accept;
   psd_result_type rsp_data;

   assign req_tready = !in_valid_ff || in_take;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_sof_ff  <= req_tuser;
      end
   end

   psd_core #(
      .DIM_BITS(DIM_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .in_sof   (in_sof_ff),
      .rsp_ready(rsp_tready),
      .in_take  (in_take),
      .rsp_valid(rsp_tvalid),
      .rsp_data (rsp_data)
   );

   assign rsp_tdata = {8'd0, rsp_data.row, rsp_data.column, rsp_data.blue, rsp_data.green,
                       rsp_data.red, rsp_data.image_height, rsp_data.image_width};
   assign rsp_tuser = {rsp_data.ascii_mode, rsp_data.kind};
   assign rsp_tlast = rsp_data.last_pixel;

endmodule

// ----- tb/tb_top.sv -----
module tb_top
   import psd_pkg::*;
();

   typedef struct packed {
      logic       sof;
      logic [7:0] data;
   } file_byte_type;

   class ppm_decode_checker;
      psd_phase_type   parse_phase;
      bit              text_mode;
      bit              comment_open;
      bit              token_open;
      bit              digits_done;
      int unsigned     token_acc;
      int unsigned     img_width;
      int unsigned     img_height;
      int unsigned     comp_sel;
      logic [7:0]      red_keep;
      logic [7:0]      green_keep;
      int unsigned     col_pos;
      int unsigned     row_pos;
      psd_result_type  decoded_due[$];
      int              fault_count;
      int              header_count;
      int              pixel_count;
      int              magic_fail_count;

      function void restart();
         parse_phase  = PH_MAGIC0;
         text_mode    = 0;
         comment_open = 0;
         token_open   = 0;
         digits_done  = 0;
         token_acc    = 0;
         img_width    = 0;
         img_height   = 0;
         comp_sel     = 0;
         red_keep     = '0;
         green_keep   = '0;
         col_pos      = 0;
         row_pos      = 0;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      // return 1 when a whitespace byte closes a token
      function bit scan_token(logic [7:0] c, bit saturate);
         int unsigned v;
         if (comment_open) begin
            if (c == CHAR_LF) comment_open = 0;
            return 0;
         end
         if (!token_open) begin
            if (is_space(c)) return 0;
            if (c == CHAR_HASH) begin
               comment_open = 1;
               return 0;
            end
            token_open  = 1;
            token_acc   = 0;
            digits_done = 0;
         end
         if (is_space(c)) begin
            token_open = 0;
            return 1;
         end
         if (!digits_done && c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = token_acc * 10 + 32'(c - CHAR_ZERO);
            if (saturate)
               token_acc = (v > (1 << DIM_BITS_DEFAULT) - 1) ?
                           (1 << DIM_BITS_DEFAULT) - 1 : v;
            else
               token_acc = v & 16'hFFFF;
         end else begin
            digits_done = 1;
         end
         return 0;
      endfunction

      function psd_result_type header_fields();
         psd_result_type r;
         r              = '0;
         r.image_width  = 16'(img_width);
         r.image_height = 16'(img_height);
         r.ascii_mode   = text_mode;
         return r;
      endfunction

      function void take_component(logic [7:0] v);
         psd_result_type r;
         bit             final_one;
         if (comp_sel == 0) begin
            red_keep = v;
            comp_sel = 1;
         end else if (comp_sel == 1) begin
            green_keep = v;
            comp_sel   = 2;
         end else begin
            comp_sel   = 0;
            final_one  = (row_pos + 1 == img_height) && (col_pos + 1 == img_width);
            r          = header_fields();
            r.kind     = KIND_PIXEL;
            r.red      = red_keep;
            r.green    = green_keep;
            r.blue     = v;
            r.column   = 16'(col_pos);
            r.row      = 16'(row_pos);
            r.last_pixel = final_one;
            decoded_due.push_back(r);
            col_pos++;
            if (col_pos >= img_width) begin
               col_pos = 0;
               row_pos++;
            end
            if (final_one || row_pos >= img_height) parse_phase = PH_DONE;
         end
      endfunction

      function void decode_byte(logic [7:0] c, logic sof);
         psd_result_type r;
         r = '0;
         if (sof) restart();
         case (parse_phase)
            PH_MAGIC0: begin
               if (c == CHAR_P) parse_phase = PH_MAGIC1_OK;
               else parse_phase = PH_MAGIC1_BAD;
            end
            PH_MAGIC1_OK, PH_MAGIC1_BAD: begin
               if (parse_phase == PH_MAGIC1_OK && (c == CHAR_3 || c == CHAR_6)) begin
                  text_mode    = (c == CHAR_3);
                  comment_open = 0;
                  token_open   = 0;
                  digits_done  = 0;
                  token_acc    = 0;
                  parse_phase  = PH_WIDTH;
               end else begin
                  parse_phase = PH_ERROR;
                  r.kind      = KIND_BAD_MAGIC;
                  decoded_due.push_back(r);
               end
            end
            PH_WIDTH: begin
               if (scan_token(c, 1'b1)) begin
                  img_width   = token_acc;
                  parse_phase = PH_HEIGHT;
               end
            end
            PH_HEIGHT: begin
               if (scan_token(c, 1'b1)) begin
                  img_height  = token_acc;
                  parse_phase = PH_MAXVAL;
               end
            end
            PH_MAXVAL: begin
               if (scan_token(c, 1'b1)) begin
                  comp_sel = 0;
                  col_pos  = 0;
                  row_pos  = 0;
                  if (img_width == 0 || img_height == 0) parse_phase = PH_DONE;
                  else if (text_mode) parse_phase = PH_PIX_TEXT;
                  else parse_phase = PH_PIX_BIN;
                  r      = header_fields();
                  r.kind = KIND_HEADER;
                  decoded_due.push_back(r);
               end
            end
            PH_PIX_TEXT: begin
               if (scan_token(c, 1'b0)) take_component(8'(token_acc & 8'hFF));
            end
            PH_PIX_BIN: take_component(c);
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
         end
      endfunction

      function void compare_output(psd_result_type got);
         psd_result_type want;
         if (decoded_due.size() == 0) begin
            $error("response with nothing due: kind %0d", got.kind);
            fault_count++;
            return;
         end
         want = decoded_due.pop_front();
         check_field("kind", 32'(want.kind), 32'(got.kind));
         check_field("image_width", 32'(want.image_width), 32'(got.image_width));
         check_field("image_height", 32'(want.image_height), 32'(got.image_height));
         check_field("ascii_mode", 32'(want.ascii_mode), 32'(got.ascii_mode));
         check_field("red", 32'(want.red), 32'(got.red));
         check_field("green", 32'(want.green), 32'(got.green));
         check_field("blue", 32'(want.blue), 32'(got.blue));
         check_field("column", 32'(want.column), 32'(got.column));
         check_field("row", 32'(want.row), 32'(got.row));
         check_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
         if (want.kind == KIND_HEADER) header_count++;
         else if (want.kind == KIND_PIXEL) pixel_count++;
         else magic_fail_count++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   ppm_decode_checker decoder_model;
   file_byte_type     file_q[$];
   bit                no_gaps;
   int                sent_count;
   int                file_count;

   ppm_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin : watch_rsp
      psd_result_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen              = '0;
         seen.kind         = rsp_tuser[1:0];
         seen.ascii_mode   = rsp_tuser[2];
         seen.image_width  = rsp_tdata[15:0];
         seen.image_height = rsp_tdata[31:16];
         seen.red          = rsp_tdata[39:32];
         seen.green        = rsp_tdata[47:40];
         seen.blue         = rsp_tdata[55:48];
         seen.column       = rsp_tdata[71:56];
         seen.row          = rsp_tdata[87:72];
         seen.last_pixel   = rsp_tlast;
         decoder_model.compare_output(seen);
      end
      rsp_tready <= no_gaps || ($urandom_range(99) >= 31);
   end

   task automatic push_byte(logic [7:0] b, logic sof);
      file_byte_type item;
      item.sof  = sof;
      item.data = b;
      file_q.push_back(item);
   endtask

   task automatic push_text(string s, bit first_sof);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], first_sof && i == 0);
   endtask

   task automatic push_blank(bit allow_comment);
      int          n;
      logic [7:0]  b;
      n = $urandom_range(1, 2);
      repeat (n) begin
         b = 8'($urandom_range(5));
         push_byte(b == 8'd5 ? CHAR_SPACE : CHAR_TAB + b, 1'b0);
      end
      if (allow_comment && $urandom_range(6) == 0) begin
         push_byte(CHAR_HASH, 1'b0);
         n = $urandom_range(5);
         repeat (n) begin
            b = 8'($urandom_range(255));
            push_byte(b == CHAR_LF ? CHAR_SPACE : b, 1'b0);
         end
         push_byte(CHAR_LF, 1'b0);
         if ($urandom_range(1)) push_byte(CHAR_SPACE, 1'b0);
      end
   endtask

   task automatic push_number(int unsigned v, bit junk);
      string marks;
      int    lead;
      marks = "x#-.a";
      lead  = ($urandom_range(6) == 0) ? $urandom_range(1, 2) : 0;
      repeat (lead) push_byte(CHAR_ZERO, 1'b0);
      push_text($sformatf("%0d", v), 1'b0);
      if (junk) push_byte(marks[$urandom_range(4)], 1'b0);
   endtask

   task automatic build_random_file();
      int unsigned pick, w, h, n, v, cut;
      bit          text;
      pick = $urandom_range(99);
      file_count++;
      if (pick < 8) begin
         push_byte(8'($urandom_range(255)), 1'b1);
         push_byte(8'($urandom_range(255)), 1'b0);
         n = $urandom_range(4);
         repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
      end else if (pick < 14) begin
         n = $urandom_range(4, 16);
         repeat (n) push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
         text = 1'($urandom_range(1));
         push_byte(CHAR_P, $urandom_range(19) != 0);
         push_byte(text ? CHAR_3 : CHAR_6, 1'b0);
         pick = $urandom_range(9);
         if (pick == 0) begin
            w = 0;
            h = $urandom_range(120000);
         end else if (pick == 1) begin
            w = $urandom_range(120000);
            h = 0;
         end else begin
            w = $urandom_range(1, 3);
            h = $urandom_range(1, 3);
         end
         if ($urandom_range(3) != 0) push_blank(1'b1);
         push_number(w, $urandom_range(9) == 0);
         push_blank(1'b1);
         push_number(h, $urandom_range(9) == 0);
         push_blank(1'b1);
         push_number($urandom_range(1, 300), $urandom_range(9) == 0);
         if (text) begin
            push_blank(1'b1);
         end else begin
            v = $urandom_range(5);
            push_byte(v == 5 ? CHAR_SPACE : CHAR_TAB + 8'(v), 1'b0);
         end
         n = (w == 0 || h == 0) ? 0 : 3 * w * h;
         repeat (n) begin
            if (text) begin
               v = ($urandom_range(4) == 0) ? $urandom_range(99999) : $urandom_range(255);
               push_number(v, $urandom_range(19) == 0);
               push_blank($urandom_range(9) == 0);
            end else begin
               push_byte(8'($urandom_range(255)), 1'b0);
            end
         end
         if ($urandom_range(9) == 0 && file_q.size() > 3) begin
            cut = $urandom_range(1, file_q.size() - 2);
            repeat (cut) void'(file_q.pop_back());
         end
         if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, 5);
            repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   task automatic send_stream();
      file_byte_type item;
      while (file_q.size() > 0) begin
         item = file_q.pop_front();
         if (!no_gaps && $urandom_range(99) < 31) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (!no_gaps && $urandom_range(99) < 31) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= item.data;
         req_tuser  <= item.sof;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         decoder_model.decode_byte(item.data, item.sof);
         sent_count++;
      end
   endtask

   initial begin
      decoder_model = new();
      decoder_model.restart();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      no_gaps    = 0;
      sent_count = 0;
      file_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_text("Q6", 1'b1);
      push_text("P5", 1'b1);
      push_text("P3#c\n1#5 1 255 300 7 12x\n9 ", 1'b1);
      push_text("P6 2 1 255\n", 1'b1);
      push_byte(CHAR_SPACE, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(CHAR_TAB, 1'b0);
      push_byte(CHAR_HASH, 1'b0);
      push_byte(8'h07, 1'b0);
      push_text("P6 99999 0 1\n", 1'b1);
      push_text("P3 x7 3 1 ", 1'b1);
      push_text("P6 3", 1'b1);
      push_text("P6 1 1 9 abc", 1'b1);
      file_count = 9;
      send_stream();

      while (sent_count < 1700) begin
         no_gaps = (sent_count >= 700 && sent_count < 1000);
         build_random_file();
         send_stream();
      end
      no_gaps = 0;
      req_tvalid <= 1'b0;

      while (decoder_model.decoded_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Fed %0d requests over %0d files (P3, P6, bad magic, noise, restarts)",
               sent_count, file_count);
      $display("Checked %0d headers, %0d pixels, %0d bad-magic errors",
               decoder_model.header_count, decoder_model.pixel_count,
               decoder_model.magic_fail_count);
      if (decoder_model.fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout waiting for requests or responses");
      $display("CHECK FAILED");
      $finish;
   end

endmodule
